// ===== sv/pdc_pkg.sv =====
package pdc_pkg;

  localparam int MaxPayloadDef = 32;
  localparam int HeaderLen     = 5;
  localparam int LenW          = 7;
  localparam int PlenW         = 7;

  localparam logic [7:0] CrcPoly      = 8'h07;
  localparam logic [7:0] CrcTop       = 8'h80;
  localparam logic [7:0] StartByteRst = 8'hAA;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY,
    PH_CHECK
  } pdc_phase_e;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_LOAD
  } pdc_em_state_e;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } pdc_status_e;

  // one frame outcome handed from the parser to the emitter
  typedef struct packed {
    logic              valid;
    pdc_status_e       status;
    logic [7:0]        frame_kind;
    logic [31:0]       sender_id;
    logic [PlenW-1:0]  plen;
  } pdc_job_t;

  // crc-8, msb first, one byte per call
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/pdc_in_if.sv =====
interface pdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

// ===== sv/pdc_out_if.sv =====
interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  frame_kind;
  logic [31:0] sender_id;
  logic [5:0]  pay_count;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        last;

  modport source (
    output valid, output status, output frame_kind, output sender_id,
    output pay_count, output payload_byte, output byte_valid, output last,
    input ready
  );
  modport sink (
    input valid, input status, input frame_kind, input sender_id,
    input pay_count, input payload_byte, input byte_valid, input last,
    output ready
  );
endinterface

// ===== sv/pdc_ram.sv =====
module pdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pdc_parser.sv =====
module pdc_parser #(
  parameter int MAX_PAYLOAD = pdc_pkg::MaxPayloadDef,
  parameter int AddrW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        start_byte_i,
  input  logic              em_idle_i,
  pdc_in_if.sink            in_ch,
  output logic              wr_en_o,
  output logic [AddrW-1:0]  wr_addr_o,
  output logic [7:0]        wr_data_o,
  output pdc_pkg::pdc_job_t job_o
);
  import pdc_pkg::*;

  localparam logic [7:0]      MaxLenB  = 8'(MAX_PAYLOAD + HeaderLen);
  localparam logic [7:0]      MinLenB  = 8'(HeaderLen);
  localparam logic [LenW-1:0] HdrCnt   = LenW'(HeaderLen);
  localparam logic [LenW-1:0] MaxPayC  = LenW'(MAX_PAYLOAD);

  pdc_phase_e      phase_q, phase_d, phase_eff;
  logic [LenW-1:0] frame_len_q, frame_len_d;
  logic [LenW-1:0] byte_cnt_q, byte_cnt_d;
  logic [LenW-1:0] pay_idx;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      type_q, type_d;
  logic [31:0]     id_q, id_d;
  logic            in_fire;
  logic [7:0]      b;

  assign in_ch.ready = em_idle_i;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign phase_eff   = in_ch.restart ? PH_HUNT : phase_q;
  assign pay_idx     = byte_cnt_q - HdrCnt;
  assign wr_addr_o   = AddrW'(pay_idx);
  assign wr_data_o   = b;

  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    byte_cnt_d  = byte_cnt_q;
    crc_d       = crc_q;
    type_d      = type_q;
    id_d        = id_q;
    wr_en_o     = 1'b0;
    job_o       = '0;
    if (in_fire) begin
      unique case (phase_eff)
        PH_HUNT: begin
          phase_d = PH_HUNT;
          if (b == start_byte_i) begin
            byte_cnt_d = '0;
            crc_d      = 8'h00;
            phase_d    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < MinLenB || b > MaxLenB) begin
            phase_d      = PH_HUNT;
            job_o.valid  = 1'b1;
            job_o.status = ST_LEN_ERR;
          end else begin
            frame_len_d = LenW'(b);
            byte_cnt_d  = '0;
            crc_d       = crc8_update(8'h00, b);
            phase_d     = PH_BODY;
          end
        end
        PH_BODY: begin
          crc_d = crc8_update(crc_q, b);
          if (byte_cnt_q == '0) begin
            type_d = b;
          end else if (byte_cnt_q < HdrCnt) begin
            id_d = {id_q[23:0], b};
          end else if (pay_idx < MaxPayC) begin
            wr_en_o = 1'b1;
          end
          byte_cnt_d = byte_cnt_q + LenW'(1);
          if (byte_cnt_d >= frame_len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d     = PH_HUNT;
          job_o.valid = 1'b1;
          if (b != crc_q) begin
            job_o.status = ST_CRC_ERR;
          end else begin
            job_o.status     = ST_GOOD;
            job_o.frame_kind = type_q;
            job_o.sender_id  = id_q;
            job_o.plen       = PlenW'(frame_len_q - HdrCnt);
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      frame_len_q <= '0;
      byte_cnt_q  <= '0;
      crc_q       <= 8'h00;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      byte_cnt_q  <= byte_cnt_d;
      crc_q       <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    id_q   <= id_d;
  end

  a_job_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_o.valid |-> in_fire)
    else $error("frame outcome without an accepted request");

  a_wr_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (in_fire && !in_ch.restart && phase_q == PH_BODY))
    else $error("payload write outside the body phase");

  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (byte_cnt_q < frame_len_q))
    else $error("body count ran past frame length");

endmodule

// ===== sv/pdc_emitter.sv =====
module pdc_emitter #(
  parameter int MAX_PAYLOAD = pdc_pkg::MaxPayloadDef,
  parameter int AddrW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdc_pkg::pdc_job_t job_i,
  output logic              em_idle_o,
  output logic              re_o,
  output logic [AddrW-1:0]  raddr_o,
  input  logic [7:0]        rdata_i,
  pdc_out_if.source         out_ch
);
  import pdc_pkg::*;

  pdc_em_state_e    state_q, state_d;
  pdc_job_t         job_q, job_d;
  logic             reads_q, reads_d;
  logic [PlenW-1:0] idx_q, idx_d;
  logic             more;
  logic             slot_free;
  logic             load;

  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [7:0]       frame_kind_q;
  logic [31:0]      sender_id_q;
  logic [5:0]       pay_count_q;
  logic [7:0]       payload_byte_q;
  logic             byte_valid_q;
  logic             last_q;

  assign slot_free = !out_valid_q || out_ch.ready;
  assign more      = reads_q && ((idx_q + PlenW'(1)) != job_q.plen);
  assign raddr_o   = AddrW'(idx_q);
  assign em_idle_o = (state_q == EM_IDLE);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    reads_d = reads_q;
    idx_d   = idx_q;
    re_o    = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      EM_IDLE: begin
        if (job_i.valid) begin
          job_d   = job_i;
          reads_d = (job_i.status == ST_GOOD) && (job_i.plen != '0);
          idx_d   = '0;
          state_d = reads_d ? EM_READ : EM_LOAD;
        end
      end
      EM_READ: begin
        re_o    = 1'b1;
        state_d = EM_LOAD;
      end
      EM_LOAD: begin
        if (slot_free) begin
          load = 1'b1;
          if (more) begin
            idx_d   = idx_q + PlenW'(1);
            state_d = EM_READ;
          end else begin
            state_d = EM_IDLE;
          end
        end
      end
      default: state_d = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    reads_q <= reads_d;
    idx_q   <= idx_d;
    if (load) begin
      status_q       <= job_q.status;
      frame_kind_q   <= job_q.frame_kind;
      sender_id_q    <= job_q.sender_id;
      pay_count_q    <= 6'(job_q.plen);
      payload_byte_q <= reads_q ? rdata_i : 8'h00;
      byte_valid_q   <= reads_q;
      last_q         <= !more;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.status       = status_q;
  assign out_ch.frame_kind   = frame_kind_q;
  assign out_ch.sender_id    = sender_id_q;
  assign out_ch.pay_count    = pay_count_q;
  assign out_ch.payload_byte = payload_byte_q;
  assign out_ch.byte_valid   = byte_valid_q;
  assign out_ch.last         = last_q;

  a_job_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_i.valid |-> (state_q == EM_IDLE))
    else $error("frame outcome arrived while emitter busy");

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EM_READ) |=> (state_q == EM_LOAD))
    else $error("read data not consumed in the following cycle");

  a_read_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EM_READ) |-> (reads_q && job_q.status == ST_GOOD))
    else $error("payload read for a frame without payload");

endmodule

// ===== sv/packet_deframer_crc8_unit.sv =====
// results: an error or empty-payload result passes through the emitter job register and then the
// output register; a good frame's payload bytes each take a payload memory read, then an output
// register load, in turn while the sink takes them
// throughput: one received byte per cycle while the emitter is idle; ready drops after each frame
// outcome until the emitter has loaded its last result, and stays low while the sink stalls
// reset: async active low; hunting for the start byte, start byte 0xAA, no memory clear
module packet_deframer_crc8_unit #(
  parameter int MAX_PAYLOAD = pdc_pkg::MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  pdc_in_if.sink     in_ch,
  pdc_out_if.source  out_ch
);
  import pdc_pkg::*;

  localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // delimiter register; the user must write it only while the block is quiet, the block does not enforce this
  logic [7:0] start_byte_q;

  // payload memory write side (parser) and read side (emitter)
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  // frame outcome and back pressure between the two halves
  pdc_job_t job;
  logic     em_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_wdata_i;
    end
  end

  // byte-level state machine: hunt, length check, header capture, crc, check byte.
  // payload bytes go straight into the memory at their offset in the payload
  pdc_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AddrW       (AddrW)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (start_byte_q),
    .em_idle_i    (em_idle),
    .in_ch        (in_ch),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .job_o        (job)
  );

  // payload store, one write and one registered read per cycle; writes and reads
  // never overlap since requests are held off while the emitter reads
  pdc_ram #(
    .Width (8),
    .Depth (MAX_PAYLOAD),
    .AddrW (AddrW)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // walks the stored payload and fills the output register, one result at a time
  pdc_emitter #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AddrW       (AddrW)
  ) u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job),
    .em_idle_o (em_idle),
    .re_o      (rd_en),
    .raddr_o   (rd_addr),
    .rdata_i   (rd_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== test/tb_packet_deframer_crc8_unit.sv =====
`timescale 1ns / 100ps

module tb_packet_deframer_crc8_unit;
  import pdc_pkg::*;

  localparam int MaxPayload   = MaxPayloadDef;
  localparam int CycleLimit   = 300000;
  // extra settling wait after every owed result has been taken
  localparam int SettleCycles = 12;
  localparam int PrintCap     = 40;

  // how the check byte of a request is formed
  typedef enum logic [1:0] {
    CB_ASIS,
    CB_GOOD,
    CB_BAD
  } chk_byte_e;

  // one result request as the output channel carries it
  typedef struct packed {
    pdc_status_e status;
    logic [7:0]  frame_kind;
    logic [31:0] sender_id;
    logic [5:0]  pay_count;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last;
  } frame_result_t;

  // one row of the directed table
  typedef struct {
    logic [7:0]    data;
    logic          rs;
    chk_byte_e     kind;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  pdc_in_if  in_ch ();
  pdc_out_if out_ch ();

  packet_deframer_crc8_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state, a private copy of what the parser holds
  pdc_phase_e  pred_phase;
  logic [6:0]  pred_len;
  logic [6:0]  pred_count;
  logic [7:0]  pred_crc;
  logic [7:0]  pred_type;
  logic [31:0] pred_id;
  logic [7:0]  pred_store [MaxPayload];
  logic [7:0]  start_byte_cfg;

  frame_result_t byte_results[$];     // results caused by the latest request
  frame_result_t awaited_results[$];  // results still owed by the block
  stim_row_t     directed_rows[$];

  int   mismatches    = 0;
  int   requests_sent = 0;
  int   cycle_count   = 0;
  bit   idle_on       = 1'b1;
  bit   stream_broken = 1'b0;

  // msb-first crc-8, poly 0x07, one data bit per round
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic frame_result_t make_result(input pdc_status_e st, input logic [7:0] typ,
                                                input logic [31:0] id, input logic [5:0] plen,
                                                input logic [7:0] pb, input logic bv,
                                                input logic lst);
    frame_result_t r;
    r.status       = st;
    r.frame_kind   = typ;
    r.sender_id    = id;
    r.pay_count    = plen;
    r.payload_byte = pb;
    r.byte_valid   = bv;
    r.last         = lst;
    return r;
  endfunction

  // error results carry only the status and last
  function automatic frame_result_t err_result(input pdc_status_e st);
    return make_result(st, 8'h00, 32'h0, 6'd0, 8'h00, 1'b0, 1'b1);
  endfunction

  function automatic stim_row_t stim_row(input logic [7:0] data, input logic rs,
                                         input chk_byte_e kind, input logic typed,
                                         input frame_result_t want);
    stim_row_t r;
    r.data  = data;
    r.rs    = rs;
    r.kind  = kind;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // advance the predictor by one received byte, results land in byte_results
  task automatic deframe_byte(input logic [7:0] b, input logic rs);
    int pos;
    int plen;
    byte_results.delete();
    if (rs) pred_phase = PH_HUNT;
    case (pred_phase)
      PH_HUNT: begin
        if (b == start_byte_cfg) begin
          pred_count = '0;
          pred_crc   = '0;
          pred_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        // length counts type, id and payload
        if (b < HeaderLen || b > MaxPayload + HeaderLen) begin
          pred_phase = PH_HUNT;
          byte_results.push_back(err_result(ST_LEN_ERR));
        end else begin
          pred_len   = b[6:0];
          pred_count = '0;
          pred_crc   = crc8_next(8'h00, b);
          pred_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        pos      = pred_count;
        pred_crc = crc8_next(pred_crc, b);
        if (pos == 0) begin
          pred_type = b;
        end else if (pos < HeaderLen) begin
          pred_id = {pred_id[23:0], b};
        end else if (pos - HeaderLen < MaxPayload) begin
          pred_store[pos - HeaderLen] = b;
        end
        pred_count = 7'(pos + 1);
        if (pred_count >= pred_len) pred_phase = PH_CHECK;
      end
      default: begin
        pred_phase = PH_HUNT;
        if (b != pred_crc) begin
          byte_results.push_back(err_result(ST_CRC_ERR));
        end else begin
          plen = int'(pred_len) - HeaderLen;
          if (plen > MaxPayload) plen = MaxPayload;
          if (plen == 0) begin
            // empty payload still reports its header once
            byte_results.push_back(make_result(ST_GOOD, pred_type, pred_id, 6'd0, 8'h00,
                                               1'b0, 1'b1));
          end else begin
            for (int i = 0; i < plen; i++) begin
              byte_results.push_back(make_result(ST_GOOD, pred_type, pred_id, 6'(plen),
                                                 pred_store[i], 1'b1, i == plen - 1));
            end
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintCap) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // present one request at a falling edge and hold it until taken;
  // returns on the falling edge after the handshake
  task automatic send_request(input logic [7:0] b, input logic rs, input chk_byte_e kind,
                              input logic typed = 1'b0,
                              input frame_result_t want = '0);
    logic [7:0] val;
    val = b;
    // check byte derived from the predictor, which has seen every earlier request
    if (kind == CB_GOOD) val = pred_crc;
    else if (kind == CB_BAD) val = pred_crc ^ 8'($urandom_range(1, 255));
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= val;
    in_ch.restart <= rs;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    deframe_byte(val, rs);
    if (typed) begin
      awaited_results.push_back(want);
    end else begin
      foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
    end
    requests_sent++;
    @(negedge clk_i);
  endtask

  // mostly well-formed frames with random content, some noise and broken ones
  task automatic send_random_frame();
    int         pick;
    int         len;
    int         n_body;
    logic       noisy;
    logic [7:0] lenb;
    pick  = $urandom_range(0, 99);
    noisy = ($urandom_range(0, 3) == 0);
    if (noisy) begin
      repeat ($urandom_range(1, 3)) send_request(8'($urandom), 1'($urandom), CB_ASIS);
    end
    // restart on the opener whenever the stream may be mid-frame
    send_request(start_byte_cfg, stream_broken || noisy || ($urandom_range(0, 4) == 0),
                 CB_ASIS);
    stream_broken = 1'b0;
    if (pick < 8) begin
      // length outside the legal window, block falls back to hunting
      lenb = $urandom_range(0, 1) ? 8'($urandom_range(0, HeaderLen - 1))
                                  : 8'($urandom_range(MaxPayload + HeaderLen + 1, 255));
      send_request(lenb, 1'b0, CB_ASIS);
      return;
    end
    if ($urandom_range(0, 9) == 0) len = MaxPayload + HeaderLen;
    else if ($urandom_range(0, 3) == 0) len = $urandom_range(HeaderLen, MaxPayload + HeaderLen);
    else len = $urandom_range(HeaderLen, HeaderLen + 7);
    send_request(8'(len), 1'b0, CB_ASIS);
    // truncated frames stop in the body or just before the check byte
    n_body = (pick < 20) ? $urandom_range(0, len) : len;
    repeat (n_body) send_request(8'($urandom), 1'b0, CB_ASIS);
    if (pick < 20) begin
      stream_broken = 1'b1;
      return;
    end
    send_request(8'h00, 1'b0, (pick < 30) ? CB_BAD : CB_GOOD);
  endtask

  // drop valid, wait for every owed result, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_start_byte(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i       <= 1'b0;
    start_byte_cfg  = value;
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = requests_sent + count;
    while (requests_sent < goal) send_random_frame();
  endtask

  // sink side, random stall bursts while idling is on
  initial begin : sink_pacing
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left    = $urandom_range(1, 13) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // every accepted result against the oldest owed one
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing owed");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(out_ch.status), 32'(want.status));
        check_field("frame_kind", 32'(out_ch.frame_kind), 32'(want.frame_kind));
        check_field("sender_id", out_ch.sender_id, want.sender_id);
        check_field("pay_count", 32'(out_ch.pay_count), 32'(want.pay_count));
        check_field("payload_byte", 32'(out_ch.payload_byte), 32'(want.payload_byte));
        check_field("byte_valid", 32'(out_ch.byte_valid), 32'(want.byte_valid));
        check_field("last", 32'(out_ch.last), 32'(want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("packet_deframer_crc8_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 8'h00;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    in_ch.restart  = 1'b0;
    pred_phase     = PH_HUNT;
    pred_len       = '0;
    pred_count     = '0;
    pred_crc       = '0;
    pred_type      = '0;
    pred_id        = '0;
    start_byte_cfg = StartByteRst;
    foreach (pred_store[i]) pred_store[i] = 8'h00;

    // directed table, start byte at its reset value
    directed_rows.push_back(stim_row(8'h00, 1'b0, CB_ASIS, 1'b0, '0)); // noise while hunting
    directed_rows.push_back(stim_row(8'hAA, 1'b1, CB_ASIS, 1'b0, '0)); // restart while hunting
    directed_rows.push_back(stim_row(8'h04, 1'b0, CB_ASIS, 1'b1, err_result(ST_LEN_ERR)));
    directed_rows.push_back(stim_row(8'hAA, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h26, 1'b0, CB_ASIS, 1'b1, err_result(ST_LEN_ERR)));
    directed_rows.push_back(stim_row(8'hAA, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'hFF, 1'b0, CB_ASIS, 1'b1, err_result(ST_LEN_ERR)));
    // shortest legal frame, start byte value inside the id, empty payload
    directed_rows.push_back(stim_row(8'hAA, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h05, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'hFF, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'hAA, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h00, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'hFF, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h5A, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h00, 1'b0, CB_GOOD, 1'b0, '0));
    // partial frame dropped by a restart that reopens on the same byte
    directed_rows.push_back(stim_row(8'hAA, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h06, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h03, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'hAA, 1'b1, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h06, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h80, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h01, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h23, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h45, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'h67, 1'b0, CB_ASIS, 1'b0, '0));
    directed_rows.push_back(stim_row(8'hC3, 1'b0, CB_ASIS, 1'b0, '0));
    // corrupted check byte
    directed_rows.push_back(stim_row(8'h00, 1'b0, CB_BAD, 1'b1, err_result(ST_CRC_ERR)));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].data, directed_rows[i].rs, directed_rows[i].kind,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    settle();

    // random phases over several start byte settings, extremes first
    write_start_byte(8'h00);
    run_random(35);
    settle();
    write_start_byte(8'hFF);
    run_random(35);
    settle();
    write_start_byte(8'($urandom_range(1, 254)));
    run_random(30);
    settle();
    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    write_start_byte(StartByteRst);
    run_random(30);
    settle();

    if (mismatches == 0) begin
      $display("packet_deframer_crc8_unit verification clean");
    end else begin
      $display("packet_deframer_crc8_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== packet_deframer_crc8_unit.f =====
sv/pdc_pkg.sv
sv/pdc_in_if.sv
sv/pdc_out_if.sv
sv/pdc_ram.sv
sv/pdc_parser.sv
sv/pdc_emitter.sv
sv/packet_deframer_crc8_unit.sv
test/tb_packet_deframer_crc8_unit.sv
